>>> rtl/core/tlwc_pkg.sv
// shared types, constants and row helpers for the two-level cache core
package tlwc_pkg;

   localparam int NEAR_SETS = 64;
   localparam int NEAR_WAYS = 4;
   localparam int FAR_SETS  = 256;
   localparam int FAR_WAYS  = 8;
   localparam int TAG_BITS  = 32;
   localparam int NS_BITS   = $clog2(NEAR_SETS);
   localparam int FS_BITS   = $clog2(FAR_SETS);
   localparam int NW_BITS   = $clog2(NEAR_WAYS);
   localparam int FW_BITS   = $clog2(FAR_WAYS);
   localparam int CYC_BITS  = 11;
   localparam int CNT_BITS  = 32;
   localparam int SUM_BITS  = 48;
   localparam int PADDR_BITS = 5;

   localparam logic [2:0] REG_BLK_SHIFT      = 3'd0;
   localparam logic [2:0] REG_WRITE_ALLOCATE = 3'd1;
   localparam logic [2:0] REG_MEM_CYCLES     = 3'd2;
   localparam logic [2:0] REG_L1_CYCLES      = 3'd3;
   localparam logic [2:0] REG_L2_CYCLES      = 3'd4;

   typedef struct packed {
      logic [3:0] blk_shift;
      logic       write_allocate;
      logic [9:0] mem_cycles;
      logic [7:0] l1_cycles;
      logic [7:0] l2_cycles;
   } cfg_type;

   typedef struct packed {
      logic                l1_hit;
      logic                l2_hit;
      logic [CYC_BITS-1:0] cyc;
   } res_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic                vld;
      logic                dty;
      logic [NW_BITS-1:0]  rank;
   } near_way_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic                vld;
      logic                dty;
      logic [FW_BITS-1:0]  rank;
   } far_way_type;

   typedef near_way_type [NEAR_WAYS-1:0] near_row_type;
   typedef far_way_type [FAR_WAYS-1:0]   far_row_type;

   typedef struct packed {
      logic               hit;
      logic [NW_BITS-1:0] way;
   } near_sel_type;

   typedef struct packed {
      logic               hit;
      logic [FW_BITS-1:0] way;
   } far_sel_type;

   function automatic near_row_type near_reset_row();
      near_row_type r;
      for (int i = 0; i < NEAR_WAYS; i++) begin
         r[i].tag  = '0;
         r[i].vld  = 1'b0;
         r[i].dty  = 1'b0;
         r[i].rank = NW_BITS'(i);
      end
      return r;
   endfunction

   function automatic far_row_type far_reset_row();
      far_row_type r;
      for (int i = 0; i < FAR_WAYS; i++) begin
         r[i].tag  = '0;
         r[i].vld  = 1'b0;
         r[i].dty  = 1'b0;
         r[i].rank = FW_BITS'(i);
      end
      return r;
   endfunction

   function automatic near_row_type near_touch(near_row_type row, logic [NW_BITS-1:0] w);
      near_row_type r;
      r = row;
      for (int i = 0; i < NEAR_WAYS; i++) begin
         if (row[i].rank < row[w].rank) r[i].rank = row[i].rank + 1'b1;
      end
      r[w].rank = '0;
      return r;
   endfunction

   function automatic far_row_type far_touch(far_row_type row, logic [FW_BITS-1:0] w);
      far_row_type r;
      r = row;
      for (int i = 0; i < FAR_WAYS; i++) begin
         if (row[i].rank < row[w].rank) r[i].rank = row[i].rank + 1'b1;
      end
      r[w].rank = '0;
      return r;
   endfunction

   function automatic near_sel_type near_find(near_row_type row, logic [TAG_BITS-1:0] blk);
      near_sel_type s;
      s = '0;
      for (int i = NEAR_WAYS - 1; i >= 0; i--) begin
         if (row[i].vld && row[i].tag == blk) begin
            s.hit = 1'b1;
            s.way = NW_BITS'(i);
         end
      end
      return s;
   endfunction

   function automatic far_sel_type far_find(far_row_type row, logic [TAG_BITS-1:0] blk);
      far_sel_type s;
      s = '0;
      for (int i = FAR_WAYS - 1; i >= 0; i--) begin
         if (row[i].vld && row[i].tag == blk) begin
            s.hit = 1'b1;
            s.way = FW_BITS'(i);
         end
      end
      return s;
   endfunction

   // lowest invalid way, else the least recent one
   function automatic logic [NW_BITS-1:0] near_pick(near_row_type row);
      logic [NW_BITS-1:0] best;
      logic               got;
      best = '0;
      for (int i = 1; i < NEAR_WAYS; i++) begin
         if (row[i].rank > row[best].rank) best = NW_BITS'(i);
      end
      got = 1'b0;
      for (int i = 0; i < NEAR_WAYS; i++) begin
         if (!got && !row[i].vld) begin
            best = NW_BITS'(i);
            got  = 1'b1;
         end
      end
      return best;
   endfunction

   function automatic logic [FW_BITS-1:0] far_pick(far_row_type row);
      logic [FW_BITS-1:0] best;
      logic               got;
      best = '0;
      for (int i = 1; i < FAR_WAYS; i++) begin
         if (row[i].rank > row[best].rank) best = FW_BITS'(i);
      end
      got = 1'b0;
      for (int i = 0; i < FAR_WAYS; i++) begin
         if (!got && !row[i].vld) begin
            best = FW_BITS'(i);
            got  = 1'b1;
         end
      end
      return best;
   endfunction

   function automatic near_row_type near_inval(near_row_type row, logic [TAG_BITS-1:0] blk);
      near_row_type r;
      near_sel_type s;
      r = row;
      s = near_find(row, blk);
      if (s.hit) begin
         r[s.way].vld = 1'b0;
         r[s.way].dty = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/tlwc_ifs.sv
// request and response channel interfaces
interface tlwc_req_if;
   logic        valid;
   logic        ready;
   logic        is_write;
   logic [31:0] address;
   modport source (output valid, is_write, address, input ready);
   modport sink (input valid, is_write, address, output ready);
endinterface

interface tlwc_rsp_if;
   logic        valid;
   logic        ready;
   logic        l1_hit;
   logic        l2_hit;
   logic [10:0] access_cycles;
   logic [31:0] l1_access_total;
   logic [31:0] l1_miss_total;
   logic [31:0] l2_access_total;
   logic [31:0] l2_miss_total;
   logic [47:0] cycle_total;
   modport source (output valid, l1_hit, l2_hit, access_cycles, l1_access_total,
      l1_miss_total, l2_access_total, l2_miss_total, cycle_total, input ready);
   modport sink (input valid, l1_hit, l2_hit, access_cycles, l1_access_total,
      l1_miss_total, l2_access_total, l2_miss_total, cycle_total, output ready);
endinterface

>>> rtl/core/tlwc_csr.sv
// configuration register block behind the apb-style port
module tlwc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tlwc_pkg::PADDR_BITS-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output tlwc_pkg::cfg_type               cfg
);
   import tlwc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr_en;

   assign idx    = paddr[PADDR_BITS-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_BLK_SHIFT:      cfg_in.blk_shift      = pwdata[3:0];
            REG_WRITE_ALLOCATE: cfg_in.write_allocate = pwdata[0];
            REG_MEM_CYCLES:     cfg_in.mem_cycles     = pwdata[9:0];
            REG_L1_CYCLES:      cfg_in.l1_cycles      = pwdata[7:0];
            REG_L2_CYCLES:      cfg_in.l2_cycles      = pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_BLK_SHIFT:      prdata = {28'd0, cfg_ff.blk_shift};
         REG_WRITE_ALLOCATE: prdata = {31'd0, cfg_ff.write_allocate};
         REG_MEM_CYCLES:     prdata = {22'd0, cfg_ff.mem_cycles};
         REG_L1_CYCLES:      prdata = {24'd0, cfg_ff.l1_cycles};
         REG_L2_CYCLES:      prdata = {24'd0, cfg_ff.l2_cycles};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blk_shift      <= 4'd2;
         cfg_ff.write_allocate <= 1'b1;
         cfg_ff.mem_cycles     <= 10'd100;
         cfg_ff.l1_cycles      <= 8'd1;
         cfg_ff.l2_cycles      <= 8'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

>>> rtl/core/tlwc_engine.sv
// tag row memories and the read-modify-write sequencer for both levels
module tlwc_engine (
   input  logic              clock,
   input  logic              reset,
   tlwc_req_if.sink          req,
   input  tlwc_pkg::cfg_type cfg,
   input  logic              out_free,
   output logic              done,
   output tlwc_pkg::res_type res
);
   import tlwc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_BI    = 3'd2;
   localparam logic [2:0] S_NFILL = 3'd3;
   localparam logic [2:0] S_WB    = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   near_row_type near_mem [NEAR_SETS];
   far_row_type  far_mem [FAR_SETS];

   logic [NEAR_SETS-1:0] near_rv_ff, near_rv_in;
   logic [FAR_SETS-1:0]  far_rv_ff, far_rv_in;

   logic [2:0]          state_ff, state_in;
   logic                wr_ff, wr_in;
   logic [TAG_BITS-1:0] blk_ff, blk_in;
   logic [TAG_BITS-1:0] vblk_ff, vblk_in;
   near_row_type        nrow_ff, nrow_in;
   res_type             res_ff, res_in;

   near_row_type        near_q_ff;
   far_row_type         far_q_ff;
   logic                near_qv_ff, far_qv_ff;

   logic                near_re, far_re, near_we, far_we;
   logic [NS_BITS-1:0]  near_raddr, near_waddr;
   logic [FS_BITS-1:0]  far_raddr, far_waddr;
   near_row_type        near_wdata, near_eff, nfill;
   far_row_type         far_wdata, far_eff, fnew;
   near_sel_type        nsel;
   far_sel_type         fsel;
   logic [NW_BITS-1:0]  npick;
   logic [FW_BITS-1:0]  fpick;
   logic                no_alloc;
   logic [TAG_BITS-1:0] req_blk;

   assign near_eff = near_qv_ff ? near_q_ff : near_reset_row();
   assign far_eff  = far_qv_ff ? far_q_ff : far_reset_row();
   assign no_alloc = wr_ff && !cfg.write_allocate;
   assign req_blk  = req.address >> cfg.blk_shift;
   assign req.ready = (state_ff == S_IDLE);
   assign done     = (state_ff == S_DONE) && out_free;
   assign res      = res_ff;

   always_comb begin
      state_in   = state_ff;
      wr_in      = wr_ff;
      blk_in     = blk_ff;
      vblk_in    = vblk_ff;
      nrow_in    = nrow_ff;
      res_in     = res_ff;
      near_re    = 1'b0;
      far_re     = 1'b0;
      near_we    = 1'b0;
      far_we     = 1'b0;
      near_raddr = blk_ff[NS_BITS-1:0];
      far_raddr  = blk_ff[FS_BITS-1:0];
      near_waddr = blk_ff[NS_BITS-1:0];
      far_waddr  = blk_ff[FS_BITS-1:0];
      near_wdata = near_eff;
      far_wdata  = far_eff;
      nsel       = near_find(near_eff, blk_ff);
      fsel       = far_find(far_eff, blk_ff);
      fpick      = far_pick(far_eff);
      npick      = near_pick(nrow_ff);
      fnew       = far_eff;
      nfill      = nrow_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               wr_in      = req.is_write;
               blk_in     = req_blk;
               near_re    = 1'b1;
               far_re     = 1'b1;
               near_raddr = req_blk[NS_BITS-1:0];
               far_raddr  = req_blk[FS_BITS-1:0];
               state_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            nrow_in       = near_eff;
            res_in.l1_hit = nsel.hit;
            res_in.l2_hit = 1'b0;
            res_in.cyc    = CYC_BITS'(cfg.l1_cycles);
            if (nsel.hit) begin
               near_wdata = near_eff;
               if (wr_ff) near_wdata[nsel.way].dty = 1'b1;
               near_wdata = near_touch(near_wdata, nsel.way);
               near_we    = 1'b1;
               state_in   = S_DONE;
            end else if (fsel.hit) begin
               res_in.l2_hit = 1'b1;
               res_in.cyc    = CYC_BITS'(cfg.l1_cycles) + CYC_BITS'(cfg.l2_cycles);
               fnew = far_touch(far_eff, fsel.way);
               if (no_alloc) begin
                  fnew[fsel.way].dty = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_NFILL;
               end
               far_wdata = fnew;
               far_we    = 1'b1;
            end else begin
               res_in.cyc = CYC_BITS'(cfg.l1_cycles) + CYC_BITS'(cfg.l2_cycles)
                  + CYC_BITS'(cfg.mem_cycles);
               if (no_alloc) begin
                  state_in = S_DONE;
               end else begin
                  // the far victim needs no write-back bookkeeping since it leaves
                  fnew[fpick].tag = blk_ff;
                  fnew[fpick].vld = 1'b1;
                  fnew[fpick].dty = wr_ff;
                  far_wdata = far_touch(fnew, fpick);
                  far_we    = 1'b1;
                  state_in  = S_NFILL;
                  if (far_eff[fpick].vld) begin
                     // back-invalidate the near copy of the far victim
                     vblk_in = far_eff[fpick].tag;
                     if (far_eff[fpick].tag[NS_BITS-1:0] == blk_ff[NS_BITS-1:0]) begin
                        nrow_in = near_inval(near_eff, far_eff[fpick].tag);
                     end else begin
                        near_re    = 1'b1;
                        near_raddr = far_eff[fpick].tag[NS_BITS-1:0];
                        state_in   = S_BI;
                     end
                  end
               end
            end
         end
         S_BI: begin
            near_waddr = vblk_ff[NS_BITS-1:0];
            near_wdata = near_inval(near_eff, vblk_ff);
            near_we    = 1'b1;
            state_in   = S_NFILL;
         end
         S_NFILL: begin
            nfill[npick].tag = blk_ff;
            nfill[npick].vld = 1'b1;
            nfill[npick].dty = wr_ff;
            near_wdata = near_touch(nfill, npick);
            near_we    = 1'b1;
            state_in   = S_DONE;
            if (nrow_ff[npick].vld && nrow_ff[npick].dty) begin
               vblk_in   = nrow_ff[npick].tag;
               far_re    = 1'b1;
               far_raddr = nrow_ff[npick].tag[FS_BITS-1:0];
               state_in  = S_WB;
            end
         end
         S_WB: begin
            // dirty near victim marks its far copy dirty and most recent
            fsel      = far_find(far_eff, vblk_ff);
            far_waddr = vblk_ff[FS_BITS-1:0];
            fnew      = far_eff;
            fnew[fsel.way].dty = 1'b1;
            far_wdata = far_touch(fnew, fsel.way);
            far_we    = fsel.hit;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      near_rv_in = near_rv_ff;
      far_rv_in  = far_rv_ff;
      if (near_we) near_rv_in[near_waddr] = 1'b1;
      if (far_we) far_rv_in[far_waddr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (near_we) near_mem[near_waddr] <= near_wdata;
      if (near_re) begin
         near_q_ff  <= near_mem[near_raddr];
         near_qv_ff <= near_rv_ff[near_raddr];
      end
      if (far_we) far_mem[far_waddr] <= far_wdata;
      if (far_re) begin
         far_q_ff  <= far_mem[far_raddr];
         far_qv_ff <= far_rv_ff[far_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         near_rv_ff <= '0;
         far_rv_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         near_rv_ff <= near_rv_in;
         far_rv_ff  <= far_rv_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ff   <= wr_in;
      blk_ff  <= blk_in;
      vblk_ff <= vblk_in;
      nrow_ff <= nrow_in;
      res_ff  <= res_in;
   end
endmodule

>>> rtl/core/two_level_lru_writeback_cache_core.sv
// top level of the two-level inclusive write-back lru cache timing core
//
// req channel: one word per access (is_write, byte address), valid/ready
// rsp channel: one word per access with hit flags, the access latency and
// saturating running totals of lookups, misses and latency
// csr port: apb-style, registers at byte offsets 0,4,8,12,16 for block size
// log, write allocate, memory, l1 and l2 latency; pready always high
//
// each access goes from acceptance to a rsp word through a near and
// far row read, then read-modify-write steps on the single-port row memories
// (back-invalidation of a near row, near fill, far write-back marking)
// a new word is accepted once the previous one sits in the rsp register,
// so the core takes no new word while an access is still in its steps
//
// reset clears the row-valid flags, so every row reads as empty with ranks
// equal to the way number; no clearing pass is needed
// a stalled rsp word holds until taken; the sequencer waits in its last step
module two_level_lru_writeback_cache_core (
   input  logic                            clock,
   input  logic                            reset,
   tlwc_req_if.sink                        req,
   tlwc_rsp_if.source                      rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tlwc_pkg::PADDR_BITS-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import tlwc_pkg::*;

   cfg_type cfg;
   res_type res;
   logic    done, out_free;

   logic                rsp_valid_ff, rsp_valid_in;
   res_type             rsp_res_ff, rsp_res_in;
   logic [CNT_BITS-1:0] l1_acc_ff, l1_acc_in, l1_miss_ff, l1_miss_in;
   logic [CNT_BITS-1:0] l2_acc_ff, l2_acc_in, l2_miss_ff, l2_miss_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SUM_BITS:0]   sum_wide;

   tlwc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tlwc_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .cfg      (cfg),
      .out_free (out_free),
      .done     (done),
      .res      (res)
   );

   // output register frees when empty or taken this cycle
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign sum_wide = {1'b0, sum_ff} + (SUM_BITS + 1)'(res.cyc);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      l1_acc_in    = l1_acc_ff;
      l1_miss_in   = l1_miss_ff;
      l2_acc_in    = l2_acc_ff;
      l2_miss_in   = l2_miss_ff;
      sum_in       = sum_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
         // saturating running totals
         if (l1_acc_ff != '1) l1_acc_in = l1_acc_ff + 1'b1;
         if (!res.l1_hit) begin
            if (l1_miss_ff != '1) l1_miss_in = l1_miss_ff + 1'b1;
            if (l2_acc_ff != '1) l2_acc_in = l2_acc_ff + 1'b1;
            if (!res.l2_hit && l2_miss_ff != '1) l2_miss_in = l2_miss_ff + 1'b1;
         end
         sum_in = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         l1_acc_ff    <= '0;
         l1_miss_ff   <= '0;
         l2_acc_ff    <= '0;
         l2_miss_ff   <= '0;
         sum_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         l1_acc_ff    <= l1_acc_in;
         l1_miss_ff   <= l1_miss_in;
         l2_acc_ff    <= l2_acc_in;
         l2_miss_ff   <= l2_miss_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.l1_hit          = rsp_res_ff.l1_hit;
   assign rsp.l2_hit          = rsp_res_ff.l2_hit;
   assign rsp.access_cycles   = rsp_res_ff.cyc;
   assign rsp.l1_access_total = l1_acc_ff;
   assign rsp.l1_miss_total   = l1_miss_ff;
   assign rsp.l2_access_total = l2_acc_ff;
   assign rsp.l2_miss_total   = l2_miss_ff;
   assign rsp.cycle_total     = sum_ff;
endmodule

>>> rtl/core/tlwc_checker.sv
// port-level checks on the response channel and its bind to the top level
module tlwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        l1_hit,
   input logic        l2_hit,
   input logic [31:0] l1_acc,
   input logic [31:0] l1_miss,
   input logic [31:0] l2_acc,
   input logic [31:0] l2_miss
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(l1_acc))
      else $error("stalled rsp word changed");

   a_one_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(l1_hit && l2_hit))
      else $error("hit flagged in both levels");

   a_l2_lookups: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> l2_acc == l1_miss)
      else $error("l2 lookups differ from l1 misses");

   a_miss_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> l1_miss <= l1_acc && l2_miss <= l2_acc)
      else $error("miss count above lookup count");
endmodule

bind two_level_lru_writeback_cache_core tlwc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .l1_hit    (rsp.l1_hit),
   .l2_hit    (rsp.l2_hit),
   .l1_acc    (rsp.l1_access_total),
   .l1_miss   (rsp.l1_miss_total),
   .l2_acc    (rsp.l2_access_total),
   .l2_miss   (rsp.l2_miss_total)
);

>>> test/two_level_lru_writeback_cache_core_test.sv
// checks the two-level write-back lru cache core against its own predictor
module two_level_lru_writeback_cache_core_test;
   import tlwc_pkg::*;

   typedef struct packed {
      logic        l1_hit;
      logic        l2_hit;
      logic [10:0] access_cycles;
      logic [31:0] l1_access_total;
      logic [31:0] l1_miss_total;
      logic [31:0] l2_access_total;
      logic [31:0] l2_miss_total;
      logic [47:0] cycle_total;
   } access_word_type;

   // predicts each access word and matches it with what the core returns
   class cache_scoreboard;
      logic [31:0] ntag[NEAR_SETS][NEAR_WAYS];
      bit          nval[NEAR_SETS][NEAR_WAYS];
      bit          ndty[NEAR_SETS][NEAR_WAYS];
      int          nrank[NEAR_SETS][NEAR_WAYS];
      logic [31:0] ftag[FAR_SETS][FAR_WAYS];
      bit          fval[FAR_SETS][FAR_WAYS];
      bit          fdty[FAR_SETS][FAR_WAYS];
      int          frank[FAR_SETS][FAR_WAYS];
      logic [31:0] n_look, n_miss, f_look, f_miss;
      logic [47:0] cyc_sum;
      cfg_type     cfg;
      access_word_type pending[$];
      int          errors;

      function new();
         for (int s = 0; s < NEAR_SETS; s++)
            for (int w = 0; w < NEAR_WAYS; w++) begin
               nval[s][w] = 0; ndty[s][w] = 0; nrank[s][w] = w;
            end
         for (int s = 0; s < FAR_SETS; s++)
            for (int w = 0; w < FAR_WAYS; w++) begin
               fval[s][w] = 0; fdty[s][w] = 0; frank[s][w] = w;
            end
         n_look = 0; n_miss = 0; f_look = 0; f_miss = 0; cyc_sum = 0;
         cfg = '{blk_shift: 4'd2, write_allocate: 1'b1, mem_cycles: 10'd100,
                 l1_cycles: 8'd1, l2_cycles: 8'd5};
         errors = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_BLK_SHIFT:      cfg.blk_shift = v[3:0];
            REG_WRITE_ALLOCATE: cfg.write_allocate = v[0];
            REG_MEM_CYCLES:     cfg.mem_cycles = v[9:0];
            REG_L1_CYCLES:      cfg.l1_cycles = v[7:0];
            REG_L2_CYCLES:      cfg.l2_cycles = v[7:0];
            default: ;
         endcase
      endfunction

      function void near_touch_way(int s, int w);
         int r;
         r = nrank[s][w];
         for (int i = 0; i < NEAR_WAYS; i++) if (nrank[s][i] < r) nrank[s][i]++;
         nrank[s][w] = 0;
      endfunction

      function void far_touch_way(int s, int w);
         int r;
         r = frank[s][w];
         for (int i = 0; i < FAR_WAYS; i++) if (frank[s][i] < r) frank[s][i]++;
         frank[s][w] = 0;
      endfunction

      // dirty near victim pushes its dirt to the far copy and makes it mru
      function void near_drop(int s, int w);
         int fs;
         if (!nval[s][w]) return;
         if (ndty[s][w]) begin
            fs = ntag[s][w] % FAR_SETS;
            for (int i = 0; i < FAR_WAYS; i++)
               if (fval[fs][i] && ftag[fs][i] == ntag[s][w]) begin
                  fdty[fs][i] = 1;
                  far_touch_way(fs, i);
                  break;
               end
         end
         nval[s][w] = 0;
         ndty[s][w] = 0;
      endfunction

      function void near_place(int s, logic [31:0] blk, bit wr);
         int w;
         w = -1;
         for (int i = 0; i < NEAR_WAYS; i++) if (w < 0 && !nval[s][i]) w = i;
         if (w < 0) begin
            w = 0;
            for (int i = 1; i < NEAR_WAYS; i++) if (nrank[s][i] > nrank[s][w]) w = i;
            near_drop(s, w);
         end
         ntag[s][w] = blk; nval[s][w] = 1; ndty[s][w] = wr;
         near_touch_way(s, w);
      endfunction

      function logic [47:0] sat(logic [47:0] a, logic [47:0] b, logic [47:0] top);
         return (a >= top || b > top - a) ? top : a + b;
      endfunction

      function void note_access(bit wr, logic [31:0] addr);
         access_word_type e;
         logic [31:0] blk;
         int ns, fs, w, ns2;
         logic [10:0] cyc;
         blk = addr >> cfg.blk_shift;
         ns = blk % NEAR_SETS;
         fs = blk % FAR_SETS;
         cyc = 11'(cfg.l1_cycles);
         e = '0;
         n_look = 32'(sat(48'(n_look), 48'd1, 48'hFFFF_FFFF));
         w = -1;
         for (int i = 0; i < NEAR_WAYS; i++)
            if (w < 0 && nval[ns][i] && ntag[ns][i] == blk) w = i;
         if (w >= 0) begin
            e.l1_hit = 1'b1;
            if (wr) ndty[ns][w] = 1;
            near_touch_way(ns, w);
         end else begin
            n_miss = 32'(sat(48'(n_miss), 48'd1, 48'hFFFF_FFFF));
            f_look = 32'(sat(48'(f_look), 48'd1, 48'hFFFF_FFFF));
            cyc += 11'(cfg.l2_cycles);
            for (int i = 0; i < FAR_WAYS; i++)
               if (w < 0 && fval[fs][i] && ftag[fs][i] == blk) w = i;
            if (w >= 0) begin
               e.l2_hit = 1'b1;
               far_touch_way(fs, w);
               if (wr && !cfg.write_allocate) fdty[fs][w] = 1;
               else near_place(ns, blk, wr);
            end else begin
               f_miss = 32'(sat(48'(f_miss), 48'd1, 48'hFFFF_FFFF));
               cyc += 11'(cfg.mem_cycles);
               if (!(wr && !cfg.write_allocate)) begin
                  for (int i = 0; i < FAR_WAYS; i++) if (w < 0 && !fval[fs][i]) w = i;
                  if (w < 0) begin
                     // far victim: back-invalidate its near copy first
                     w = 0;
                     for (int i = 1; i < FAR_WAYS; i++)
                        if (frank[fs][i] > frank[fs][w]) w = i;
                     ns2 = ftag[fs][w] % NEAR_SETS;
                     for (int i = 0; i < NEAR_WAYS; i++)
                        if (nval[ns2][i] && ntag[ns2][i] == ftag[fs][w]) begin
                           near_drop(ns2, i);
                           break;
                        end
                     fval[fs][w] = 0; fdty[fs][w] = 0;
                  end
                  ftag[fs][w] = blk; fval[fs][w] = 1; fdty[fs][w] = wr;
                  far_touch_way(fs, w);
                  near_place(ns, blk, wr);
               end
            end
         end
         cyc_sum = sat(cyc_sum, 48'(cyc), 48'hFFFF_FFFF_FFFF);
         e.access_cycles = cyc;
         e.l1_access_total = n_look;
         e.l1_miss_total = n_miss;
         e.l2_access_total = f_look;
         e.l2_miss_total = f_miss;
         e.cycle_total = cyc_sum;
         pending.push_back(e);
      endfunction

      function void field(string name, logic [47:0] exp_v, logic [47:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_result(access_word_type a);
         access_word_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t unexpected word, expected none actual %h", $time, a);
            return;
         end
         e = pending.pop_front();
         field("l1_hit", 48'(e.l1_hit), 48'(a.l1_hit));
         field("l2_hit", 48'(e.l2_hit), 48'(a.l2_hit));
         field("access_cycles", 48'(e.access_cycles), 48'(a.access_cycles));
         field("l1_access_total", 48'(e.l1_access_total), 48'(a.l1_access_total));
         field("l1_miss_total", 48'(e.l1_miss_total), 48'(a.l1_miss_total));
         field("l2_access_total", 48'(e.l2_access_total), 48'(a.l2_access_total));
         field("l2_miss_total", 48'(e.l2_miss_total), 48'(a.l2_miss_total));
         field("cycle_total", e.cycle_total, a.cycle_total);
      endfunction
   endclass

   logic clock, reset;
   logic psel, penable, pwrite;
   logic [PADDR_BITS-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   tlwc_req_if req_if();
   tlwc_rsp_if rsp_if();

   two_level_lru_writeback_cache_core uut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   cache_scoreboard sb = new();
   int sender_idle_pct;   // chance in a hundred of an idle cycle before a word
   int stall_pct;         // chance in a hundred that rsp ready is low
   int hold_cycles;       // long receiver hold-off, counted down below

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // receiver: random stalls, a counted hold-off, and the word check
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result('{rsp_if.l1_hit, rsp_if.l2_hit, rsp_if.access_cycles,
                           rsp_if.l1_access_total, rsp_if.l1_miss_total,
                           rsp_if.l2_access_total, rsp_if.l2_miss_total,
                           rsp_if.cycle_total});
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // apb write: setup cycle, then access cycle; pready is always high
   task automatic write_register(logic [2:0] idx, logic [31:0] v);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= PADDR_BITS'(idx) << 2; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_register(idx, v);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // offer one word, with random idle cycles ahead of it
   task automatic send_access(bit wr, logic [31:0] addr);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.is_write <= wr;
      req_if.address <= addr;
      do @(posedge clock); while (!req_if.ready);
      sb.note_access(wr, addr);
   endtask

   // mostly blocks crowding a few sets so evictions and back-invalidation occur
   function automatic logic [31:0] pick_address();
      logic [31:0] blk;
      int r;
      r = $urandom_range(99);
      if (r < 15) return $urandom;
      if (r < 75) blk = ($urandom_range(0, 15) << 8) | $urandom_range(0, 3);
      else blk = ($urandom_range(0, 63) << 8) | $urandom_range(0, 255);
      return (blk << sb.cfg.blk_shift)
             | ($urandom & ((32'd1 << sb.cfg.blk_shift) - 1));
   endfunction

   // let every expected word arrive, then a few spare cycles
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_config(int bsl, int wa, int mem, int l1, int l2);
      write_register(REG_BLK_SHIFT, bsl);
      write_register(REG_WRITE_ALLOCATE, wa);
      write_register(REG_MEM_CYCLES, mem);
      write_register(REG_L1_CYCLES, l1);
      write_register(REG_L2_CYCLES, l2);
   endtask

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_if.valid = 1'b0; req_if.is_write = 1'b0; req_if.address = '0;
      rsp_if.ready = 1'b0;
      sender_idle_pct = 0; stall_pct = 0; hold_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: edges of the address, repeat hits, write hits,
      // then ten blocks into one far set to force eviction of dirty lines
      send_access(0, 32'h0);
      send_access(0, 32'h0);
      send_access(1, 32'h0);
      send_access(0, 32'hFFFF_FFFF);
      send_access(1, 32'hFFFF_FFFF);
      for (int k = 1; k <= 10; k++) send_access(k[0], k << 10);
      send_access(0, 32'h0);
      send_access(1, 32'h0000_0400);
      drain();
      // no-write-allocate: a write hit in near, write misses to memory, then a read of an unallocated block
      write_register(REG_WRITE_ALLOCATE, 0);
      send_access(1, 32'h0000_2800);
      send_access(1, 32'h0000_1000);
      send_access(1, 32'hABCD_0000);
      send_access(0, 32'hABCD_0000);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_config(2, 1, 100, 1, 5);
            1: set_config(0, 0, 1023, 255, 255);
            2: set_config(12, 1, 0, 0, 0);
            3: set_config(15, 0, $urandom_range(1023), $urandom_range(255),
                          $urandom_range(255));
            default: set_config($urandom_range(12), 1, $urandom_range(1023),
                                $urandom_range(255), $urandom_range(255));
         endcase
         sender_idle_pct = (ph == 1) ? 83 : (ph == 3) ? 8 : 0;
         stall_pct = (ph == 2) ? 83 : (ph == 3) ? 8 : 0;
         if (ph == 0) hold_cycles = 300;
         for (int n = 0; n < 190; n++) send_access($urandom_range(1), pick_address());
         drain();
      end

      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
